@@ design/spr_pkg.sv @@
package spr_pkg;

    localparam int COORD_W  = 16;
    localparam int SLOT_W   = 4;
    localparam int MASK_W   = 16;
    localparam int CFG_W    = 5;
    localparam int CFG_RST  = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_LATCH,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
    } box_t;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
    } pair_sel_t;

endpackage

@@ design/spr_box_mem.sv @@
module spr_box_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  spr_pkg::box_t       wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output spr_pkg::box_t       rd_data
);

    spr_pkg::box_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/spr_pair_unit.sv @@
module spr_pair_unit (
    input  spr_pkg::box_t      box_a,
    input  spr_pkg::box_t      box_b,
    input  spr_pkg::pair_sel_t sel,
    output logic               hit
);

    logic a_good;
    logic b_good;
    logic x_touch;
    logic y_touch;

    // inverted boxes take part in nothing
    assign a_good = ($signed(box_a.min_x) <= $signed(box_a.max_x))
                 && ($signed(box_a.min_y) <= $signed(box_a.max_y));
    assign b_good = ($signed(box_b.min_x) <= $signed(box_b.max_x))
                 && ($signed(box_b.min_y) <= $signed(box_b.max_y));

    // touching edges count as overlap
    assign x_touch = ($signed(box_a.min_x) <= $signed(box_b.max_x))
                  && ($signed(box_b.min_x) <= $signed(box_a.max_x));
    assign y_touch = ($signed(box_a.min_y) <= $signed(box_b.max_y))
                  && ($signed(box_b.min_y) <= $signed(box_a.max_y));

    assign hit = sel.a_ok && sel.b_ok && a_good && b_good && x_touch && y_touch;

endmodule

@@ design/sweep_prune_box_overlap_top.sv @@
// channel   signals                                          direction
// input     in_valid/in_ready, operation, slot, min_x,       in
//           max_x, min_y, max_y, is_active
// output    out_valid/out_ready, report_slot, overlap_mask,  out
//           last_report
// config    cfg_we, cfg_data (slots_in_use)                  in
//
// a run compares each of the N slots in use, row by row, against every slot in use,
// one slot pair per cycle while scanning, through the single pair compare unit
// and the one read port of the box memory
// reset clears all active flags, slots_in_use returns to 16
// in_ready is low while a run scans; a stalled output word holds the scan at
// the end of its row
module sweep_prune_box_overlap_top #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [spr_pkg::SLOT_W-1:0]          slot,
    input  logic signed [spr_pkg::COORD_W-1:0]  min_x,
    input  logic signed [spr_pkg::COORD_W-1:0]  max_x,
    input  logic signed [spr_pkg::COORD_W-1:0]  min_y,
    input  logic signed [spr_pkg::COORD_W-1:0]  max_y,
    input  logic                                is_active,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [spr_pkg::SLOT_W-1:0]          report_slot,
    output logic [spr_pkg::MASK_W-1:0]          overlap_mask,
    output logic                                last_report,
    input  logic                                cfg_we,
    input  logic [spr_pkg::CFG_W-1:0]           cfg_data
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    spr_pkg::state_t            state_reg;
    spr_pkg::state_t            state_next;
    logic [spr_pkg::CFG_W-1:0]  cfg_reg;
    logic [MAX_SLOTS-1:0]       active_reg;
    logic [IDX_W-1:0]           row_reg;
    logic [IDX_W-1:0]           col_reg;
    spr_pkg::box_t              a_box_reg;
    logic                       a_act_reg;
    logic [MAX_SLOTS-1:0]       mask_reg;
    logic [MAX_SLOTS-1:0]       mask_next;
    logic                       out_valid_reg;
    logic [spr_pkg::SLOT_W-1:0] out_slot_reg;
    logic [spr_pkg::MASK_W-1:0] out_mask_reg;
    logic                       out_last_reg;

    logic [CNT_W-1:0]           used;
    logic                       row_last;
    logic                       col_last;
    logic                       load_hit;
    logic                       run_hit;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       latch_a;
    logic                       step;
    logic                       emit;
    spr_pkg::box_t              wr_box;
    spr_pkg::box_t              rd_box;
    spr_pkg::pair_sel_t         sel;
    logic                       hit;

    // effective slot count: zero acts as one, saturate at the store depth
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            used = CNT_W'(1);
        end
        else if (32'(cfg_reg) > MAX_SLOTS)
        begin
            used = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            used = CNT_W'(cfg_reg);
        end
    end

    assign row_last = (CNT_W'(row_reg) + CNT_W'(1)) == used;
    assign col_last = (CNT_W'(col_reg) + CNT_W'(1)) == used;

    assign in_ready = (state_reg == spr_pkg::ST_IDLE);
    assign load_hit = in_valid && in_ready && (operation == spr_pkg::OP_LOAD)
                   && (32'(slot) < MAX_SLOTS);
    assign run_hit  = in_valid && in_ready && (operation == spr_pkg::OP_RUN);

    assign wr_box = '{min_x: min_x, max_x: max_x, min_y: min_y, max_y: max_y};

    spr_box_mem #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (IDX_W)
    ) u_box_mem (
        .clk     (clk),
        .wr_en   (load_hit),
        .wr_addr (IDX_W'(slot)),
        .wr_data (wr_box),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_box)
    );

    assign sel.a_ok = a_act_reg;
    assign sel.b_ok = active_reg[col_reg] && (col_reg != row_reg);

    spr_pair_unit u_pair_unit (
        .box_a (a_box_reg),
        .box_b (rd_box),
        .sel   (sel),
        .hit   (hit)
    );

    assign mask_next = mask_reg | (MAX_SLOTS'(hit) << col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = row_reg;
        latch_a    = 1'b0;
        step       = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            spr_pkg::ST_IDLE:
            begin
                if (run_hit)
                begin
                    state_next = spr_pkg::ST_ROW_RD;
                end
            end
            spr_pkg::ST_ROW_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = row_reg;
                state_next = spr_pkg::ST_ROW_LATCH;
            end
            spr_pkg::ST_ROW_LATCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                latch_a    = 1'b1;
                state_next = spr_pkg::ST_SCAN;
            end
            spr_pkg::ST_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = col_reg + IDX_W'(1);
                step    = 1'b1;
                if (col_last)
                begin
                    state_next = spr_pkg::ST_EMIT;
                end
            end
            spr_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit       = 1'b1;
                    state_next = row_last ? spr_pkg::ST_IDLE : spr_pkg::ST_ROW_RD;
                end
            end
            default:
            begin
                state_next = spr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= spr_pkg::CFG_W'(spr_pkg::CFG_RST);
            active_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            if (load_hit)
            begin
                active_reg[IDX_W'(slot)] <= is_active;
            end
            if (run_hit)
            begin
                row_reg <= '0;
            end
            else if (emit)
            begin
                row_reg <= row_reg + IDX_W'(1);
            end
            if (latch_a)
            begin
                col_reg <= '0;
            end
            else if (step)
            begin
                col_reg <= col_reg + IDX_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (latch_a)
        begin
            a_box_reg <= rd_box;
            a_act_reg <= active_reg[row_reg];
            mask_reg  <= '0;
        end
        else if (step)
        begin
            mask_reg <= mask_next;
        end
        if (emit)
        begin
            out_slot_reg <= spr_pkg::SLOT_W'(row_reg);
            out_mask_reg <= spr_pkg::MASK_W'(mask_reg);
            out_last_reg <= row_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign report_slot  = out_slot_reg;
    assign overlap_mask = out_mask_reg;
    assign last_report  = out_last_reg;

    // a slot never lists itself
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !overlap_mask[report_slot])
        else $error("report lists its own slot");

    // slots beyond the count in use never appear in a word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((32'(overlap_mask) >> used) == 32'd0))
        else $error("mask names a slot beyond slots in use");

    // the scan column and row stay inside the slots in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spr_pkg::ST_SCAN) |-> ((CNT_W'(col_reg) < used)
            && (CNT_W'(row_reg) < used)))
        else $error("scan index past slots in use");

    // a run start always begins at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        run_hit |=> (state_reg == spr_pkg::ST_ROW_RD) && (row_reg == '0))
        else $error("run did not start at slot zero");

endmodule
